/* hdl/servo_ramp_pwm_controller_assert.svh */
// assertion macros for the servo ramp controller
// all macros sample on clk and are disabled while rst is high
`ifndef SERVO_RAMP_PWM_CONTROLLER_ASSERT_SVH
`define SERVO_RAMP_PWM_CONTROLLER_ASSERT_SVH

// condition must hold on every clock edge
`define SRPC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define SRPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the cycle after the antecedent
`define SRPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srpc_pkg;

  // command codes
  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_SET_ANGLE    = 3'd1;
  localparam logic [2:0] OP_SOFT_TARGET  = 3'd2;
  localparam logic [2:0] OP_SET_INITIAL  = 3'd3;
  localparam logic [2:0] OP_REQUEST_STOP = 3'd4;
  localparam logic [2:0] OP_CLEAR_STOP   = 3'd5;

  // register indexes
  localparam int          REG_IDX_W        = 3;
  localparam logic [2:0]  REG_MIN_ANGLE    = 3'd0;
  localparam logic [2:0]  REG_MAX_ANGLE    = 3'd1;
  localparam logic [2:0]  REG_MIN_PULSE    = 3'd2;
  localparam logic [2:0]  REG_MAX_PULSE    = 3'd3;
  localparam logic [2:0]  REG_STEP_SIZE    = 3'd4;
  localparam logic [2:0]  REG_ENABLE_DELAY = 3'd5;

  // tick reports at most this many channels
  localparam int MAX_REPORT = 4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // reset angles in 1/16 degree
  localparam logic [11:0] ANGLE_RESET_DEFAULT = 12'd1440;
  localparam logic [11:0] ANGLE_RESET_CH3     = 12'd640;

  // pulse = min + (angle*span + 1440) / 2880; 2880 = 64 * 45
  localparam logic [24:0] PULSE_ROUND = 25'd1440;
  // ceil(2^24 / 45), exact for every dividend below 2^18
  localparam logic [18:0] RECIP_45    = 19'd372828;
  localparam logic [13:0] PULSE_MAX   = 14'd4095;

  typedef struct packed {
    logic [11:0] min_angle;
    logic [11:0] max_angle;
    logic [11:0] min_pulse;
    logic [11:0] max_pulse;
    logic [11:0] step_size;
    logic [15:0] enable_delay;
  } cfg_t;

  // classified command as it waits in the queue
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  ch;
    logic        ch_ok;
    logic [11:0] ang;
  } q_entry_t;

endpackage

`default_nettype wire

/* hdl/srpc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpc_front #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // channel[1:0], angle[14:2], zero[15]
  input  logic [2:0]         s_tuser,   // opcode[2:0]
  input  srpc_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output srpc_pkg::q_entry_t q_entry
);
  import srpc_pkg::*;

  logic [1:0]         ch;
  logic signed [12:0] ang_raw;
  logic signed [13:0] ang_ext;
  logic signed [13:0] lo_lim;
  logic signed [13:0] hi_lim;
  logic [11:0]        ang_clamped;

  assign ch      = s_tdata[1:0];
  assign ang_raw = s_tdata[14:2];
  assign ang_ext = 14'(ang_raw);
  assign lo_lim  = $signed({2'b00, cfg.min_angle});
  assign hi_lim  = $signed({2'b00, cfg.max_angle});

  // clamp, lower bound checked first
  always_comb begin
    if (ang_ext < lo_lim) begin
      ang_clamped = cfg.min_angle;
    end else if (ang_ext > hi_lim) begin
      ang_clamped = cfg.max_angle;
    end else begin
      ang_clamped = ang_raw[11:0];
    end
  end

  // accept while the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_entry.op    = s_tuser;
    q_entry.ch    = ch;
    q_entry.ch_ok = (32'(ch) < NUM_CHANNELS);
    q_entry.ang   = ang_clamped;
  end

endmodule

`default_nettype wire

/* hdl/srpc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  srpc_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output srpc_pkg::q_entry_t pop_data
);
  import srpc_pkg::*;

  q_entry_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W:0]      count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/srpc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpc_back #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srpc_pkg::cfg_t          cfg,
  input  logic                    q_valid,
  input  srpc_pkg::q_entry_t      q_entry,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // out_channel[1:0], pulse_width[13:2], present_angle[25:14], enabled[26],
  // ramping[27], stopped[28], zero[31:29]
  output logic [31:0]             m_tdata,
  output logic                    m_tlast,
  output logic                    stopped,
  output logic [NUM_CHANNELS-1:0] ramp_mask
);
  import srpc_pkg::*;

  localparam int CW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NREP = (NUM_CHANNELS < MAX_REPORT) ? NUM_CHANNELS : MAX_REPORT;
  localparam logic [CW-1:0] LAST_CH  = CW'(NUM_CHANNELS - 1);
  localparam logic [CW-1:0] LAST_REP = CW'(NREP - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // channel state
  logic [11:0]             angle_mem  [NUM_CHANNELS];
  logic [11:0]             target_mem [NUM_CHANNELS];
  logic [15:0]             wait_mem   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] en_flags;
  logic [NUM_CHANNELS-1:0] ramp_flags;
  logic                    stop_flag;

  // sequencer and latched command
  logic [2:0]    state;
  logic [CW-1:0] cur_ch;
  logic [2:0]    op_r;
  logic [1:0]    ch_r;
  logic          ok_r;
  logic [11:0]   ang_r;

  // pulse datapath
  logic [23:0]   prod_r;
  logic [37:0]   qm_r;

  logic [11:0]   cur_angle;
  logic [11:0]   cur_tgt;
  logic [15:0]   cur_wait;
  logic          cur_en;
  logic          cur_ramp;
  logic [11:0]   st;
  logic [11:0]   remain;
  logic          is_tick;
  logic          rpt_ok;
  logic          out_free;
  logic [11:0]   span;
  logic [24:0]   round_sum;
  logic [18:0]   div_in;
  logic [12:0]   quot;
  logic [13:0]   psum;
  logic [11:0]   pulse_sat;

  assign cur_angle = angle_mem[cur_ch];
  assign cur_tgt   = target_mem[cur_ch];
  assign cur_wait  = wait_mem[cur_ch];
  assign cur_en    = en_flags[cur_ch];
  assign cur_ramp  = ramp_flags[cur_ch];
  assign is_tick   = (op_r == OP_TICK);
  assign rpt_ok    = is_tick || ok_r;
  assign out_free  = !m_tvalid || m_tready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign stopped   = stop_flag;
  assign ramp_mask = ramp_flags;

  // step unit
  assign st     = (cfg.step_size == '0) ? 12'd1 : cfg.step_size;
  assign remain = (cur_angle > cur_tgt) ? (cur_angle - cur_tgt) : (cur_tgt - cur_angle);

  // pulse arithmetic: multiply, round, divide by 64 then by 45
  assign span      = (cfg.max_pulse >= cfg.min_pulse) ? (cfg.max_pulse - cfg.min_pulse) : '0;
  assign round_sum = 25'(prod_r) + PULSE_ROUND;
  assign div_in    = round_sum[24:6];
  assign quot      = qm_r[36:24];
  assign psum      = 14'(cfg.min_pulse) + 14'(quot);
  assign pulse_sat = (psum > PULSE_MAX) ? 12'(PULSE_MAX) : psum[11:0];

  // sequencer, channel state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_ch    <= '0;
      op_r      <= OP_TICK;
      ch_r      <= '0;
      ok_r      <= 1'b0;
      ang_r     <= '0;
      en_flags  <= '0;
      ramp_flags <= '0;
      stop_flag <= 1'b0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        angle_mem[i]  <= (i == 3) ? ANGLE_RESET_CH3 : ANGLE_RESET_DEFAULT;
        target_mem[i] <= '0;
        wait_mem[i]   <= '0;
      end
    end else begin
      // output valid: raised with a new result, dropped once taken
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op_r   <= q_entry.op;
            ch_r   <= q_entry.ch;
            ok_r   <= q_entry.ch_ok;
            ang_r  <= q_entry.ang;
            cur_ch <= (q_entry.op == OP_TICK) ? '0 : CW'(q_entry.ch);
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_tick) begin
            state <= S_TICK;
          end else begin
            unique case (op_r)
              OP_SET_ANGLE: begin
                if (ok_r) begin
                  angle_mem[cur_ch]  <= ang_r;
                  en_flags[cur_ch]   <= 1'b1;
                  ramp_flags[cur_ch] <= 1'b0;
                  wait_mem[cur_ch]   <= '0;
                end
              end
              OP_SOFT_TARGET: begin
                if (ok_r && !stop_flag) begin
                  target_mem[cur_ch] <= ang_r;
                  if (!cur_en) begin
                    en_flags[cur_ch] <= 1'b1;
                    wait_mem[cur_ch] <= cfg.enable_delay;
                  end
                  ramp_flags[cur_ch] <= 1'b1;
                end
              end
              OP_SET_INITIAL: begin
                if (ok_r && !cur_en) begin
                  angle_mem[cur_ch] <= ang_r;
                end
              end
              OP_REQUEST_STOP: begin
                stop_flag  <= 1'b1;
                ramp_flags <= '0;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                  wait_mem[i] <= '0;
                end
              end
              OP_CLEAR_STOP: begin
                stop_flag <= 1'b0;
              end
              default: begin
              end
            endcase
            state <= S_MUL;
          end
        end
        S_TICK: begin
          // one channel per cycle through the step unit
          if (cur_ramp) begin
            if (cur_wait != '0) begin
              wait_mem[cur_ch] <= cur_wait - 1'b1;
            end else if (remain <= st) begin
              angle_mem[cur_ch]  <= cur_tgt;
              ramp_flags[cur_ch] <= 1'b0;
            end else if (cur_angle < cur_tgt) begin
              angle_mem[cur_ch] <= cur_angle + st;
            end else begin
              angle_mem[cur_ch] <= cur_angle - st;
            end
          end
          if (cur_ch == LAST_CH) begin
            cur_ch <= '0;
            state  <= S_MUL;
          end else begin
            cur_ch <= cur_ch + 1'b1;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (is_tick && (cur_ch != LAST_REP)) begin
              cur_ch <= cur_ch + 1'b1;
              state  <= S_MUL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // pulse pipeline and result register
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod_r <= 24'(cur_angle) * 24'(span);
    end
    if (state == S_DIV) begin
      qm_r <= 38'(div_in) * 38'(RECIP_45);
    end
    if ((state == S_OUT) && out_free) begin
      m_tdata[1:0]   <= is_tick ? 2'(cur_ch) : ch_r;
      m_tdata[13:2]  <= (rpt_ok && cur_en) ? pulse_sat : '0;
      m_tdata[25:14] <= rpt_ok ? cur_angle : '0;
      m_tdata[26]    <= rpt_ok && cur_en;
      m_tdata[27]    <= rpt_ok && cur_ramp;
      m_tdata[28]    <= stop_flag;
      m_tdata[31:29] <= '0;
      m_tlast        <= !is_tick || (cur_ch == LAST_REP);
    end
  end

endmodule

`default_nettype wire

/* hdl/servo_ramp_pwm_controller.sv */
// Multi-channel servo slew controller with pulse-width output.
// Commands and ticks enter on the s_ channel (opcode in s_tuser, channel and
// signed angle in s_tdata). Each command returns one status transfer on the
// m_ channel with m_tlast set; a tick returns one transfer per channel for
// the first four channels, channel 0 first, m_tlast on the final one.
// The user must write registers via cfg_we/cfg_addr/cfg_wdata only while
// idle; the block itself does not enforce it. A front stage clamps and
// classifies each command into a two-entry queue; the back sequencer
// executes one queued item at a time. A command goes from the queue through
// load, execute, multiply, divide and output. A tick is loaded and executed,
// steps every channel through the shared step unit, then passes each
// reported channel through the shared pulse datapath (multiply, divide,
// output). The next item leaves the queue right after a result registers,
// so an item never starts before the previous result is registered.
// If m_tready is low the finished result holds in the output register and
// the sequencer waits; the queue keeps taking inputs until it is full.
// Reset (rst, synchronous) restores register defaults, all channels
// disabled, angles 90 degrees (channel 3 at 40), stop flag clear.
`timescale 1ns / 1ps
`default_nettype none

module servo_ramp_pwm_controller #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel[1:0], angle[14:2], zero[15]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_channel[1:0], pulse_width[13:2], present_angle[25:14], enabled[26],
  // ramping[27], stopped[28], zero[31:29]
  output logic [31:0] m_tdata,
  output logic        m_tlast
);
  import srpc_pkg::*;

  cfg_t                    cfg;
  logic                    q_full;
  logic                    q_push;
  q_entry_t                push_entry;
  logic                    q_valid;
  logic                    q_pop;
  q_entry_t                pop_entry;
  logic                    stopped;
  logic [NUM_CHANNELS-1:0] ramp_mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angle    <= 12'd0;
      cfg.max_angle    <= 12'd2880;
      cfg.min_pulse    <= 12'd500;
      cfg.max_pulse    <= 12'd2500;
      cfg.step_size    <= 12'd16;
      cfg.enable_delay <= 16'd25;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_ANGLE:    cfg.min_angle    <= cfg_wdata[11:0];
        REG_MAX_ANGLE:    cfg.max_angle    <= cfg_wdata[11:0];
        REG_MIN_PULSE:    cfg.min_pulse    <= cfg_wdata[11:0];
        REG_MAX_PULSE:    cfg.max_pulse    <= cfg_wdata[11:0];
        REG_STEP_SIZE:    cfg.step_size    <= cfg_wdata[11:0];
        REG_ENABLE_DELAY: cfg.enable_delay <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  srpc_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  srpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_entry)
  );

  srpc_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .stopped   (stopped),
    .ramp_mask (ramp_mask)
  );

`include "servo_ramp_pwm_controller_assert.svh"

  // stop aborts every ramp and blocks new ones
  `SRPC_ASSERT_IMPL(a_stop_no_ramp, stopped, ramp_mask == '0, "ramp active while stopped")
  // a ramping channel is always an enabled one
  `SRPC_ASSERT_IMPL(a_ramp_enabled, m_tvalid && m_tdata[27], m_tdata[26],
                    "ramping result on disabled channel")
  // the sequencer takes one queued item and then works on it
  `SRPC_ASSERT_NEXT(a_single_pop, q_pop, !q_pop, "back popped on consecutive cycles")

endmodule

`default_nettype wire

/* tb/sv/servo_ramp_pwm_controller_tb.sv */
`timescale 1ns / 1ps

module servo_ramp_pwm_controller_tb;
  import srpc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int NUM_CH = 4;
  localparam int MAX_PRINTED = 30;

  // signed 13-bit angle corners
  localparam logic [12:0] ANG_NEG_MOST  = 13'h1000;
  localparam logic [12:0] ANG_POS_MOST  = 13'h0FFF;
  localparam logic [12:0] ANG_MINUS_ONE = 13'h1FFF;

  // predicted channel status, checked against each output transfer
  class slew_status_predictor;
    typedef struct packed {
      logic [1:0]  ch;
      logic [11:0] pulse;
      logic [11:0] angle;
      logic        en;
      logic        ramp;
      logic        stop;
      logic        last;
    } status_t;

    cfg_t        regs;
    logic [11:0] angle_of[NUM_CH];
    logic [11:0] target_of[NUM_CH];
    bit          enabled_of[NUM_CH];
    bit          ramping_of[NUM_CH];
    int unsigned hold_of[NUM_CH];
    bit          stop_all;
    status_t     due_reports[$];
    int          fault_count;
    int          checked_count;

    function new();
      regs.min_angle    = 12'd0;
      regs.max_angle    = 12'd2880;
      regs.min_pulse    = 12'd500;
      regs.max_pulse    = 12'd2500;
      regs.step_size    = 12'd16;
      regs.enable_delay = 16'd25;
      for (int c = 0; c < NUM_CH; c++) begin
        angle_of[c]   = (c == 3) ? ANGLE_RESET_CH3 : ANGLE_RESET_DEFAULT;
        target_of[c]  = 12'd0;
        enabled_of[c] = 1'b0;
        ramping_of[c] = 1'b0;
        hold_of[c]    = 0;
      end
      stop_all = 1'b0;
      fault_count = 0;
      checked_count = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_MIN_ANGLE:    regs.min_angle    = val[11:0];
        REG_MAX_ANGLE:    regs.max_angle    = val[11:0];
        REG_MIN_PULSE:    regs.min_pulse    = val[11:0];
        REG_MAX_PULSE:    regs.max_pulse    = val[11:0];
        REG_STEP_SIZE:    regs.step_size    = val[11:0];
        REG_ENABLE_DELAY: regs.enable_delay = val;
        default: ;
      endcase
    endfunction

    // low bound is tested first, so it wins when the bounds cross
    function logic [11:0] clamp(logic [12:0] raw);
      int a;
      a = int'($signed(raw));
      if (a < int'(regs.min_angle)) return regs.min_angle;
      if (a > int'(regs.max_angle)) return regs.max_angle;
      return a[11:0];
    endfunction

    function logic [11:0] pulse_of(int c);
      int span;
      int p;
      if (!enabled_of[c]) return 12'd0;
      span = (regs.max_pulse >= regs.min_pulse) ?
             int'(regs.max_pulse) - int'(regs.min_pulse) : 0;
      p = int'(regs.min_pulse) + (int'(angle_of[c]) * span + 1440) / 2880;
      return (p > 4095) ? 12'd4095 : p[11:0];
    endfunction

    function void push_status(int c, bit last);
      status_t s;
      s.ch    = c[1:0];
      s.pulse = pulse_of(c);
      s.angle = angle_of[c];
      s.en    = enabled_of[c];
      s.ramp  = ramping_of[c];
      s.stop  = stop_all;
      s.last  = last;
      due_reports.push_back(s);
    endfunction

    // one slew step, or one count of the enable hold
    function void step_channel(int c);
      int cur;
      int tgt;
      int st;
      int remain;
      if (!ramping_of[c]) return;
      if (hold_of[c] > 0) begin
        hold_of[c]--;
        return;
      end
      cur    = int'(angle_of[c]);
      tgt    = int'(target_of[c]);
      st     = (regs.step_size == 12'd0) ? 1 : int'(regs.step_size);
      remain = (cur > tgt) ? cur - tgt : tgt - cur;
      if (remain <= st) begin
        angle_of[c]   = target_of[c];
        ramping_of[c] = 1'b0;
      end else if (cur < tgt) begin
        angle_of[c] = 12'(cur + st);
      end else begin
        angle_of[c] = 12'(cur - st);
      end
    endfunction

    function void note_accepted(logic [2:0] op, logic [1:0] ch, logic [12:0] ang);
      int c;
      c = int'(ch);
      if (op == OP_TICK) begin
        for (int k = 0; k < NUM_CH; k++) step_channel(k);
        for (int k = 0; k < NUM_CH; k++) push_status(k, k == NUM_CH - 1);
      end else begin
        case (op)
          OP_SET_ANGLE: begin
            angle_of[c]   = clamp(ang);
            enabled_of[c] = 1'b1;
            ramping_of[c] = 1'b0;
            hold_of[c]    = 0;
          end
          OP_SOFT_TARGET: begin
            if (!stop_all) begin
              target_of[c] = clamp(ang);
              if (!enabled_of[c]) begin
                enabled_of[c] = 1'b1;
                hold_of[c]    = int'(regs.enable_delay);
              end
              ramping_of[c] = 1'b1;
            end
          end
          OP_SET_INITIAL: begin
            if (!enabled_of[c]) angle_of[c] = clamp(ang);
          end
          OP_REQUEST_STOP: begin
            stop_all = 1'b1;
            for (int k = 0; k < NUM_CH; k++) begin
              ramping_of[k] = 1'b0;
              hold_of[k]    = 0;
            end
          end
          OP_CLEAR_STOP: stop_all = 1'b0;
          default: ;
        endcase
        push_status(c, 1'b1);
      end
    endfunction

    task report(string field, int got, int want);
      fault_count++;
      if (fault_count <= MAX_PRINTED)
        $display("%0t: bad %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    task check_report(logic [31:0] data, logic last);
      status_t want;
      if (due_reports.size() == 0) begin
        report("transfer with nothing pending, data", int'(data), 0);
        return;
      end
      want = due_reports.pop_front();
      checked_count++;
      if (data[1:0] != want.ch) report("out_channel", int'(data[1:0]), int'(want.ch));
      if (data[13:2] != want.pulse) report("pulse_width", int'(data[13:2]), int'(want.pulse));
      if (data[25:14] != want.angle)
        report("present_angle", int'(data[25:14]), int'(want.angle));
      if (data[26] != want.en) report("enabled", int'(data[26]), int'(want.en));
      if (data[27] != want.ramp) report("ramping", int'(data[27]), int'(want.ramp));
      if (data[28] != want.stop) report("stopped", int'(data[28]), int'(want.stop));
      if (last != want.last) report("last", int'(last), int'(want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = 3'd0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;   // channel[1:0], angle[14:2], zero[15]
  logic [2:0]  s_tuser = 3'd0;    // opcode[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // out_channel[1:0], pulse_width[13:2], present_angle[25:14], enabled[26],
  // ramping[27], stopped[28], zero[31:29]
  logic [31:0] m_tdata;
  logic        m_tlast;

  slew_status_predictor status_model = new();

  int tick_count = 0;
  int command_count = 0;
  int setting_count = 0;
  int idle_cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_run_left = 0;
  int rx_stall_left = 0;

  servo_ramp_pwm_controller dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) status_model.check_report(m_tdata, m_tlast);
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_quiet) begin
      m_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else if (rx_run_left > 0) begin
      rx_run_left--;
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 3) != 0) begin
      rx_run_left = $urandom_range(0, 23);
      m_tready <= 1'b1;
    end else begin
      rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 3);
      m_tready <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, status_model.due_reports.size());
      $display("servo_ramp_pwm_controller: mismatch");
      $finish;
    end
  end

  // sender gap: mostly none or short, now and then long
  function automatic int sender_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // angle near the configured range, raw noise, or a corner value
  function automatic logic [12:0] pick_angle();
    int lo;
    int hi;
    int v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      lo = int'(status_model.regs.min_angle);
      hi = int'(status_model.regs.max_angle);
      if (lo > hi) begin
        v = lo;
        lo = hi;
        hi = v;
      end
      v = lo - 20 + int'($urandom_range(0, hi - lo + 40));
      if (v > 4095) v = 4095;
      return v[12:0];
    end
    if (r < 80) return 13'($urandom);
    case ($urandom_range(0, 5))
      0: return ANG_NEG_MOST;
      1: return ANG_POS_MOST;
      2: return 13'd0;
      3: return ANG_MINUS_ONE;
      4: return {1'b0, status_model.regs.min_angle};
      default: return {1'b0, status_model.regs.max_angle};
    endcase
  endfunction

  // offer one item, wait for its transfer, then maybe idle
  task automatic send_item(logic [2:0] op, logic [1:0] ch, logic [12:0] ang);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, ang, ch};
    do @(posedge clk); while (!s_tready);
    status_model.note_accepted(op, ch, ang);
    if (op == OP_TICK) tick_count++;
    else command_count++;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted result has arrived
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (status_model.due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_one(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    status_model.write_reg(idx, val);
    @(posedge clk);
  endtask

  // 12-bit registers get random junk in the unused upper bits
  task automatic write_config(int min_a, int max_a, int min_p, int max_p, int step,
                              int delay);
    setting_count++;
    write_one(REG_MIN_ANGLE, {4'($urandom), 12'(min_a)});
    write_one(REG_MAX_ANGLE, {4'($urandom), 12'(max_a)});
    write_one(REG_MIN_PULSE, {4'($urandom), 12'(min_p)});
    write_one(REG_MAX_PULSE, {4'($urandom), 12'(max_p)});
    write_one(REG_STEP_SIZE, {4'($urandom), 12'(step)});
    write_one(REG_ENABLE_DELAY, 16'(delay));
    cfg_we <= 1'b0;
  endtask

  // mostly ramp sequences with random content, some stop traffic and noise
  task automatic random_scenario();
    int kind;
    int n;
    logic [1:0] c;
    kind = $urandom_range(0, 99);
    c = 2'($urandom_range(0, 3));
    if (kind < 55) begin
      if (status_model.stop_all && $urandom_range(0, 1) == 1)
        send_item(OP_CLEAR_STOP, 2'($urandom), pick_angle());
      if ($urandom_range(0, 3) == 0) send_item(OP_SET_INITIAL, c, pick_angle());
      send_item(OP_SOFT_TARGET, c, pick_angle());
      n = $urandom_range(2, 10);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) send_item(OP_SOFT_TARGET, 2'($urandom), pick_angle());
        else send_item(OP_TICK, 2'($urandom), pick_angle());
      end
    end else if (kind < 68) begin
      send_item(OP_REQUEST_STOP, c, pick_angle());
      send_item(OP_SOFT_TARGET, c, pick_angle());
      send_item(OP_TICK, c, pick_angle());
      if ($urandom_range(0, 3) != 0) send_item(OP_CLEAR_STOP, 2'($urandom), pick_angle());
    end else if (kind < 80) begin
      send_item(OP_SET_ANGLE, c, pick_angle());
      send_item(OP_TICK, 2'($urandom), pick_angle());
    end else begin
      send_item(3'($urandom_range(0, 7)), c, pick_angle());
    end
  endtask

  task automatic run_phase(int items);
    int start;
    start = tick_count + command_count;
    while (tick_count + command_count - start < items) random_scenario();
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset settings
    send_item(OP_TICK, 2'd0, 13'd0);               // reset pose, all disabled
    send_item(OP_SET_INITIAL, 2'd3, ANG_NEG_MOST); // clamps to the low bound
    send_item(OP_SET_INITIAL, 2'd2, ANG_POS_MOST); // clamps to the high bound
    send_item(OP_SET_ANGLE, 2'd0, 13'd0);
    send_item(OP_SET_ANGLE, 2'd1, 13'd2880);
    send_item(OP_SET_INITIAL, 2'd0, 13'd100);      // ignored, channel enabled
    send_item(OP_SOFT_TARGET, 2'd2, 13'd1000);     // enables and starts the hold
    send_item(OP_TICK, 2'd1, ANG_MINUS_ONE);       // waiting tick
    send_item(OP_SOFT_TARGET, 2'd1, 13'd2870);     // within one step
    send_item(OP_TICK, 2'd2, 13'd0);               // lands on the target
    send_item(OP_SOFT_TARGET, 2'd0, 13'd40);
    send_item(OP_TICK, 2'd3, 13'd0);               // one step up
    send_item(OP_REQUEST_STOP, 2'd0, 13'd0);
    send_item(OP_SOFT_TARGET, 2'd0, 13'd2000);     // ignored while stopped
    send_item(OP_TICK, 2'd0, 13'd0);
    send_item(OP_CLEAR_STOP, 2'd2, 13'd0);
    send_item(3'd6, 2'd1, 13'd55);                 // unused opcodes
    send_item(3'd7, 2'd3, ANG_MINUS_ONE);
    send_item(OP_SOFT_TARGET, 2'd3, 13'd300);
    send_item(OP_SOFT_TARGET, 2'd2, 13'd1200);     // enabled: hold count kept
    send_item(OP_SET_ANGLE, 2'd3, 13'd500);        // cancels the ramp
    send_item(OP_TICK, 2'd0, 13'd0);
    drain_outputs();

    // crossed bounds, no idling on either side
    write_config(2880, 0, 500, 2500, 16, 0);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_phase(25);
    drain_outputs();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // full angle range and full pulse span, pulse saturates
    write_config(0, 4095, 0, 4095, 2880, 0);
    send_item(OP_SET_ANGLE, 2'd0, ANG_POS_MOST);
    send_item(OP_TICK, 2'd0, 13'd0);
    run_phase(25);
    drain_outputs();

    // result side holds off while the sender keeps offering
    rx_hold_req = HOLD_CYCLES;
    tx_quiet = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 1) == 1) send_item(OP_TICK, 2'($urandom), pick_angle());
      else send_item(OP_SOFT_TARGET, 2'($urandom), pick_angle());
    end
    tx_quiet = 1'b0;
    drain_outputs();

    // inverted pulse bounds, zero step
    write_config(100, 2000, 4095, 0, 0, 3);
    run_phase(25);
    drain_outputs();

    // unit step, longest hold
    write_config(0, 2880, 1000, 2000, 1, 65535);
    run_phase(20);
    drain_outputs();

    // random settings
    repeat (3) begin
      write_config($urandom_range(0, 1440), $urandom_range(1440, 2880),
                   $urandom_range(0, 1500), $urandom_range(1500, 4095),
                   $urandom_range(1, 400), $urandom_range(0, 6));
      rx_quiet = ($urandom_range(0, 2) == 0);
      run_phase(20);
      drain_outputs();
    end

    $display("covered %0d ticks and %0d commands over %0d register settings",
             tick_count, command_count, setting_count + 1);
    $display("%0d result transfers checked, %0d field errors",
             status_model.checked_count, status_model.fault_count);
    if (status_model.fault_count == 0) begin
      $display("servo_ramp_pwm_controller: match");
    end else begin
      $display("servo_ramp_pwm_controller: mismatch");
    end
    $finish;
  end

endmodule
